### sv/tcp_client_connection_engine_unit_macros.svh
// Assertion macros used by the connection engine top level.
`ifndef TCP_CLIENT_CONNECTION_ENGINE_UNIT_MACROS_SVH
`define TCP_CLIENT_CONNECTION_ENGINE_UNIT_MACROS_SVH
`define TCE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TCE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### sv/tce_pkg.sv
// Package with types, codes and constants of the connection engine.
`default_nettype none
package tce_pkg;
   localparam logic [5:0] F_FIN = 6'h01;
   localparam logic [5:0] F_SYN = 6'h02;
   localparam logic [5:0] F_RST = 6'h04;
   localparam logic [5:0] F_ACK = 6'h10;
   localparam logic [6:0] A_ACKED = 7'h01;
   localparam logic [6:0] A_CONNECTED = 7'h02;
   localparam logic [6:0] A_NEWDATA = 7'h04;
   localparam logic [6:0] A_CLOSE = 7'h08;
   localparam logic [6:0] A_ABORT = 7'h10;
   localparam logic [6:0] A_REXMIT = 7'h20;
   localparam logic [6:0] A_INACTIVE = 7'h40;
   localparam logic [16:0] UNACK_MAX = 17'h1FFFF;
   localparam int CSR_ADDR_W = 5;

   typedef enum logic [1:0] {
      CMD_CONNECT = 2'd0, CMD_TICK = 2'd1, CMD_SEGMENT = 2'd2, CMD_SEND = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      M_DISC = 3'd0, M_WAIT = 3'd1, M_CONN = 3'd2, M_LAST = 3'd3, M_TOUT = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      R_REMOTE_PORT = 3'd0, R_FIRST_LOCAL = 3'd1, R_RTO_INIT = 3'd2,
      R_MAX_RETX = 3'd3, R_MAX_SYN = 3'd4, R_INACT = 3'd5
   } reg_type;

   typedef struct packed {
      logic [15:0] remote_port;
      logic [3:0]  rto_initial;
      logic [3:0]  max_retx;
      logic [3:0]  max_syn_retx;
      logic [15:0] inactivity_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic        ip_match;
      logic [15:0] seg_src_port;
      logic [15:0] seg_dst_port;
      logic [31:0] seg_seq;
      logic [31:0] seg_ack;
      logic [5:0]  seg_flags;
      logic [15:0] length;
      logic [31:0] init_seq;
   } req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [5:0]  tx_flags;
      logic [15:0] tx_src_port;
      logic [15:0] tx_dst_port;
      logic [31:0] tx_seq;
      logic [31:0] tx_ack;
      logic        tx_mss_option;
      logic [15:0] tx_data_len;
      logic [6:0]  app_flags;
      logic [2:0]  conn_state;
      logic        new_data;
   } rsp_type;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] lport;
      logic [31:0] lseq;
      logic [31:0] rseq;
      logic [16:0] unacked;
      logic [7:0]  timer;
      logic [7:0]  timeout;
      logic [7:0]  sa;
      logic [7:0]  sv;
      logic [3:0]  rcount;
      logic [6:0]  flags;
      logic [15:0] idle;
   } st_type;
endpackage
`default_nettype wire

### sv/tce_if.sv
// Valid/ready channel interfaces for request and response beats.
`default_nettype none
interface tce_req_if;
   logic valid;
   logic ready;
   tce_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tce_rsp_if;
   logic valid;
   logic ready;
   tce_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/tce_step.sv
// Combinational next-state and response logic for one event.
`default_nettype none
module tce_step (
   input  tce_pkg::st_type  st_i,
   input  tce_pkg::cfg_type cfg_i,
   input  tce_pkg::req_type req_i,
   output tce_pkg::st_type  st_o,
   output tce_pkg::rsp_type rsp_o
);
   import tce_pkg::*;

   always_comb begin
      st_type s;
      rsp_type r;
      logic [2:0] sh;
      logic [7:0] m;
      logic [7:0] ma;
      logic [17:0] usum;
      logic done;
      logic do_rst;
      s = st_i;
      r = '0;
      done = 1'b0;
      do_rst = 1'b0;
      sh = '0;
      m = '0;
      ma = '0;
      usum = '0;
      unique case (cmd_type'(req_i.cmd))
         CMD_CONNECT: begin
            s.lseq = req_i.init_seq;
            s.rseq = '0;
            s.lport = st_i.lport + 16'd1;
            s.unacked = 17'd1;
            s.timer = {4'd0, cfg_i.rto_initial};
            s.timeout = {4'd0, cfg_i.rto_initial};
            s.sa = '0;
            s.sv = 8'd16;
            s.rcount = '0;
            s.mode = M_WAIT;
            s.idle = '0;
            r.tx_valid = 1'b1;
            r.tx_flags = F_SYN;
            r.tx_mss_option = 1'b1;
            r.tx_seq = s.lseq;
            r.tx_src_port = s.lport;
            r.tx_dst_port = cfg_i.remote_port;
         end
         CMD_SEND: begin
            if (st_i.mode == M_CONN) begin
               r.tx_valid = 1'b1;
               r.tx_flags = F_ACK;
               r.tx_mss_option = 1'b1;
               r.tx_data_len = req_i.length;
               r.tx_src_port = st_i.lport;
               r.tx_dst_port = cfg_i.remote_port;
               r.tx_seq = st_i.lseq;
               r.tx_ack = st_i.rseq;
               if ((st_i.flags & A_REXMIT) == '0) begin
                  usum = {1'b0, st_i.unacked} + {2'b0, req_i.length};
                  s.unacked = usum[17] ? UNACK_MAX : usum[16:0];
                  s.timer = st_i.timeout;
                  s.rcount = '0;
               end
            end
         end
         default: begin
            if (st_i.flags != '0) s.idle = '0;
            s.flags = '0;
            if (req_i.cmd == CMD_TICK && s.idle != 16'hFFFF) s.idle = s.idle + 16'd1;
            if (s.idle >= cfg_i.inactivity_ticks) s.flags = s.flags | A_INACTIVE;
            if (st_i.mode == M_TOUT) begin
               s.mode = M_DISC;
            end else if (st_i.mode != M_DISC) begin
               logic rc;
               logic [5:0] fl;
               fl = req_i.seg_flags;
               rc = 1'b0;
               if (req_i.cmd == CMD_TICK) begin
                  if (s.unacked != '0) s.timer = s.timer - 8'd1;
                  rc = 1'b1;
               end else if (!req_i.ip_match || req_i.seg_src_port != cfg_i.remote_port) begin
                  rc = 1'b1;
               end else if (req_i.seg_dst_port != s.lport) begin
                  if ((fl & F_SYN) != '0) rc = 1'b1;
                  else do_rst = 1'b1;
               end else if ((fl & F_RST) != '0) begin
                  s.mode = M_DISC;
                  s.flags = A_ABORT;
               end else if (!(s.mode == M_WAIT && (fl & (F_SYN | F_ACK)) != '0) &&
                            (req_i.length != '0 || (fl & F_FIN) != '0) &&
                            req_i.seg_seq != s.rseq) begin
                  r.tx_valid = 1'b1;
                  r.tx_flags = F_ACK;
               end else begin
                  if ((fl & F_ACK) != '0 && s.unacked != '0 &&
                      req_i.seg_ack == s.lseq + {15'd0, s.unacked}) begin
                     s.lseq = s.lseq + {15'd0, s.unacked};
                     if (s.rcount == '0) begin
                        m = s.timeout - s.timer;
                        m = m - {3'd0, s.sa[7:3]};
                        s.sa = s.sa + m;
                        ma = m[7] ? 8'd0 - m : m;
                        ma = ma - {2'd0, s.sv[7:2]};
                        s.sv = s.sv + ma;
                        s.timeout = {3'd0, s.sa[7:3]} + s.sv;
                     end
                     s.timer = s.timeout;
                     s.unacked = '0;
                     s.flags = A_ACKED;
                  end
                  unique case (s.mode)
                     M_WAIT: begin
                        if ((s.flags & A_ACKED) != '0 && (fl & (F_SYN | F_ACK)) != '0) begin
                           s.mode = M_CONN;
                           s.rseq = req_i.seg_seq + 32'd1;
                           s.flags = A_CONNECTED;
                           r.tx_valid = 1'b1;
                           r.tx_flags = F_ACK;
                        end else begin
                           s.flags = A_ABORT;
                           s.mode = M_DISC;
                           do_rst = 1'b1;
                        end
                     end
                     M_CONN: begin
                        if ((fl & F_FIN) != '0) begin
                           if (s.unacked != '0) rc = 1'b1;
                           else begin
                              s.rseq = s.rseq + {16'd0, req_i.length} + 32'd1;
                              s.flags = s.flags | A_CLOSE;
                              if (req_i.length != '0) s.flags = s.flags | A_NEWDATA;
                              s.unacked = 17'd1;
                              s.mode = M_LAST;
                              s.rcount = '0;
                              r.tx_valid = 1'b1;
                              r.tx_flags = F_FIN | F_ACK;
                           end
                        end else if (req_i.length != '0) begin
                           s.flags = s.flags | A_NEWDATA;
                           s.rseq = s.rseq + {16'd0, req_i.length};
                           r.tx_valid = 1'b1;
                           r.tx_flags = F_ACK;
                        end else rc = 1'b1;
                     end
                     M_LAST: begin
                        if ((s.flags & A_ACKED) != '0) begin
                           s.mode = M_DISC;
                           s.flags = A_CLOSE;
                        end else rc = 1'b1;
                     end
                     default: begin
                        r.tx_valid = 1'b1;
                        r.tx_flags = F_ACK;
                     end
                  endcase
               end
               if (rc && s.unacked != '0 && s.timer == '0) begin
                  sh = (s.rcount > 4'd4) ? 3'd4 : s.rcount[2:0];
                  s.timer = 8'({4'd0, cfg_i.rto_initial} << sh);
                  if (s.rcount == cfg_i.max_retx ||
                      (s.mode == M_WAIT && s.rcount == cfg_i.max_syn_retx)) begin
                     s.mode = M_TOUT;
                     r.tx_valid = 1'b1;
                     r.tx_flags = F_RST | F_ACK;
                  end else begin
                     s.rcount = s.rcount + 4'd1;
                     if (s.mode == M_WAIT) begin
                        r.tx_valid = 1'b1;
                        r.tx_flags = F_SYN;
                        r.tx_mss_option = 1'b1;
                     end else if (s.mode == M_CONN) s.flags = s.flags | A_REXMIT;
                     else if (s.mode == M_LAST) begin
                        r.tx_valid = 1'b1;
                        r.tx_flags = F_FIN | F_ACK;
                     end
                  end
               end
               if (r.tx_valid) begin
                  r.tx_src_port = s.lport;
                  r.tx_dst_port = cfg_i.remote_port;
                  r.tx_seq = s.lseq;
                  r.tx_ack = s.rseq;
               end
               if (do_rst) begin
                  if ((fl & F_RST) == '0) begin
                     r.tx_valid = 1'b1;
                     r.tx_flags = F_RST | F_ACK;
                     r.tx_src_port = req_i.seg_dst_port;
                     r.tx_dst_port = cfg_i.remote_port;
                     r.tx_seq = req_i.seg_ack;
                     r.tx_ack = req_i.seg_seq + 32'd1;
                     r.tx_mss_option = 1'b0;
                  end
               end
            end
            r.new_data = (s.flags & A_NEWDATA) != '0;
            done = 1'b1;
         end
      endcase
      r.app_flags = s.flags;
      r.conn_state = s.mode;
      st_o = s;
      rsp_o = r;
      if (done) rsp_o.app_flags = s.flags;
   end
endmodule
`default_nettype wire

### sv/tcp_client_connection_engine_unit.sv
// Top level of the TCP client connection engine.
// One request beat is one event: connect, tick, received segment header or
// application send. Every request beat gives exactly one response beat with
// the header to transmit (tx_valid marks it), the application flags and the
// connection state after the event.
// A request accepted at a clock edge is shown on the response channel from the
// next cycle. One event is taken per cycle unless the receiver stalls;
// the whole state update is one pass of combinational logic between the
// connection state registers and the response register.
// If the receiver stalls, the one response register holds its beat and
// req_ready stays low until it is taken, so no beat is lost.
// Reset loads the register defaults, resets the connection state and leaves
// the response channel empty. Registers are written through the csr_ port, at byte address
// 4 times the register index; the user must write only while no event is pending (not enforced).
`default_nettype none
module tcp_client_connection_engine_unit (
   input  wire logic clock,
   input  wire logic reset,
   tce_req_if.sink   req,
   tce_rsp_if.source rsp,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [tce_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import tce_pkg::*;

   st_type  st_ff, st_in;
   cfg_type cfg_ff;
   logic [15:0] first_ff;
   rsp_type rsp_ff, rsp_in;
   logic valid_ff;
   logic take;
   logic wr;
   reg_type ridx;

   assign ridx = reg_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign req.ready = !valid_ff || rsp.ready;
   assign take = req.valid && req.ready;
   assign rsp.valid = valid_ff;
   assign rsp.data = rsp_ff;

   tce_step u_step (.st_i(st_ff), .cfg_i(cfg_ff), .req_i(req.data),
                    .st_o(st_in), .rsp_o(rsp_in));

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'd0) begin
         unique case (ridx)
            R_REMOTE_PORT: csr_prdata = {16'd0, cfg_ff.remote_port};
            R_FIRST_LOCAL: csr_prdata = {16'd0, first_ff};
            R_RTO_INIT:    csr_prdata = {28'd0, cfg_ff.rto_initial};
            R_MAX_RETX:    csr_prdata = {28'd0, cfg_ff.max_retx};
            R_MAX_SYN:     csr_prdata = {28'd0, cfg_ff.max_syn_retx};
            R_INACT:       csr_prdata = {16'd0, cfg_ff.inactivity_ticks};
            default:       csr_prdata = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.remote_port <= '0;
         first_ff <= 16'd49152;
         cfg_ff.rto_initial <= 4'd3;
         cfg_ff.max_retx <= 4'd8;
         cfg_ff.max_syn_retx <= 4'd5;
         cfg_ff.inactivity_ticks <= 16'd1200;
         st_ff <= '{mode: M_DISC, lport: 16'd49152, sv: 8'd16, default: '0};
         valid_ff <= 1'b0;
      end else begin
         if (take) begin
            st_ff <= st_in;
            rsp_ff <= rsp_in;
            valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
         if (wr && csr_paddr[1:0] == 2'd0) begin
            unique case (ridx)
               R_REMOTE_PORT: cfg_ff.remote_port <= csr_pwdata[15:0];
               R_FIRST_LOCAL: begin
                  first_ff <= csr_pwdata[15:0];
                  st_ff.lport <= csr_pwdata[15:0];
               end
               R_RTO_INIT:    cfg_ff.rto_initial <= csr_pwdata[3:0];
               R_MAX_RETX:    cfg_ff.max_retx <= csr_pwdata[3:0];
               R_MAX_SYN:     cfg_ff.max_syn_retx <= csr_pwdata[3:0];
               R_INACT:       cfg_ff.inactivity_ticks <= csr_pwdata[15:0];
               default: ;
            endcase
         end
      end
   end

`include "tcp_client_connection_engine_unit_macros.svh"
   `TCE_ASSERT_NXT(a_take_valid, clock, reset, take, valid_ff, "accepted beat gave no response")
   `TCE_ASSERT_NXT(a_hold, clock, reset, valid_ff && !rsp.ready, $stable(rsp_ff), "stalled beat changed")
   `TCE_ASSERT_IMP(a_txz, clock, reset, valid_ff && !rsp_ff.tx_valid, rsp_ff.tx_flags == '0, "idle header not zero")
   `TCE_ASSERT_NXT(a_conn, clock, reset, take && req.data.cmd == CMD_CONNECT, st_ff.mode == M_WAIT, "connect did not open")
endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the TCP client connection engine: random and directed events.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import tce_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   tce_req_if req ();
   tce_rsp_if rsp ();

   tcp_client_connection_engine_unit u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Predicted engine state and configuration.
   logic [15:0] c_rport, c_flport, c_inact;
   logic [3:0]  c_rto, c_mretx, c_msyn;
   mode_type    s_mode;
   logic [15:0] s_lport, s_idle;
   logic [31:0] s_lseq, s_rseq;
   logic [16:0] s_unack;
   logic [7:0]  s_timer, s_tout, s_sa, s_sv;
   logic [3:0]  s_rcnt;
   logic [6:0]  s_flags;
   rsp_type     out_hdr;

   req_type pending_events[$];
   rsp_type expected_beats[$];
   int mismatches = 0;
   int beats_checked = 0;
   int sent_segments = 0;
   int idle_watch = 0;
   int hold_off = 0;

   function automatic void model_reset();
      c_rport = 0; c_flport = 16'd49152; c_rto = 3; c_mretx = 8; c_msyn = 5;
      c_inact = 16'd1200;
      s_mode = M_DISC; s_lport = c_flport; s_lseq = 0; s_rseq = 0; s_unack = 0;
      s_timer = 0; s_tout = 0; s_sa = 0; s_sv = 16; s_rcnt = 0; s_flags = 0;
      s_idle = 0;
   endfunction

   function automatic void model_config(reg_type idx, logic [15:0] v);
      case (idx)
         R_REMOTE_PORT: c_rport = v;
         R_FIRST_LOCAL: begin
            c_flport = v; s_lport = v;
         end
         R_RTO_INIT: c_rto = v[3:0];
         R_MAX_RETX: c_mretx = v[3:0];
         R_MAX_SYN: c_msyn = v[3:0];
         R_INACT: c_inact = v;
         default: ;
      endcase
   endfunction

   function automatic void emit_hdr(logic [5:0] fl, logic [15:0] src, logic [15:0] dst,
                                    logic [31:0] sq, logic [31:0] ak, logic mss,
                                    logic [15:0] len);
      out_hdr.tx_valid = 1'b1; out_hdr.tx_flags = fl; out_hdr.tx_src_port = src;
      out_hdr.tx_dst_port = dst; out_hdr.tx_seq = sq; out_hdr.tx_ack = ak;
      out_hdr.tx_mss_option = mss; out_hdr.tx_data_len = len;
   endfunction

   function automatic void emit_own(logic [5:0] fl, logic mss, logic [15:0] len);
      emit_hdr(fl, s_lport, c_rport, s_lseq, s_rseq, mss, len);
   endfunction

   function automatic void retransmit_check();
      int sh;
      if (s_unack == 0 || s_timer != 0) return;
      sh = s_rcnt > 4 ? 4 : s_rcnt;
      s_timer = 8'({4'd0, c_rto} << sh);
      if (s_rcnt == c_mretx || (s_mode == M_WAIT && s_rcnt == c_msyn)) begin
         s_mode = M_TOUT;
         emit_own(F_RST | F_ACK, 0, 0);
         return;
      end
      s_rcnt = s_rcnt + 1;
      if (s_mode == M_WAIT) emit_own(F_SYN, 1, 0);
      else if (s_mode == M_CONN) s_flags |= A_REXMIT;
      else if (s_mode == M_LAST) emit_own(F_FIN | F_ACK, 0, 0);
   endfunction

   function automatic void reset_reply(req_type e);
      if (e.seg_flags & F_RST) return;
      emit_hdr(F_RST | F_ACK, e.seg_dst_port, c_rport, e.seg_ack, e.seg_seq + 32'd1, 0, 0);
   endfunction

   function automatic void rtt_estimate();
      logic [7:0] m;
      m = s_tout - s_timer;
      m = m - (s_sa >> 3);
      s_sa = s_sa + m;
      if (m[7]) m = -m;
      m = m - (s_sv >> 2);
      s_sv = s_sv + m;
      s_tout = (s_sa >> 3) + s_sv;
   endfunction

   function automatic void segment_event(req_type e);
      logic [5:0] fl;
      fl = e.seg_flags;
      if (!e.ip_match || e.seg_src_port != c_rport) begin
         retransmit_check(); return;
      end
      if (e.seg_dst_port != s_lport) begin
         if (fl & F_SYN) retransmit_check();
         else reset_reply(e);
         return;
      end
      if (fl & F_RST) begin
         s_mode = M_DISC; s_flags = A_ABORT; return;
      end
      if (!(s_mode == M_WAIT && (fl & (F_SYN | F_ACK))))
         if ((e.length > 0 || (fl & F_FIN)) && e.seg_seq != s_rseq) begin
            emit_own(F_ACK, 0, 0); return;
         end
      if ((fl & F_ACK) && s_unack > 0 && e.seg_ack == s_lseq + 32'(s_unack)) begin
         s_lseq = s_lseq + 32'(s_unack);
         if (s_rcnt == 0) rtt_estimate();
         s_timer = s_tout;
         s_unack = 0;
         s_flags = A_ACKED;
      end
      if (s_mode == M_WAIT) begin
         if ((s_flags & A_ACKED) && (fl & (F_SYN | F_ACK))) begin
            s_mode = M_CONN; s_rseq = e.seg_seq + 1; s_flags = A_CONNECTED;
            emit_own(F_ACK, 0, 0); return;
         end
         s_flags = A_ABORT; s_mode = M_DISC;
         reset_reply(e); return;
      end
      if (s_mode == M_CONN) begin
         if (fl & F_FIN) begin
            if (s_unack > 0) begin
               retransmit_check(); return;
            end
            s_rseq = s_rseq + 32'(e.length) + 1;
            s_flags |= A_CLOSE;
            if (e.length > 0) s_flags |= A_NEWDATA;
            s_unack = 1; s_mode = M_LAST; s_rcnt = 0;
            emit_own(F_FIN | F_ACK, 0, 0); return;
         end
         if (e.length > 0) begin
            s_flags |= A_NEWDATA; s_rseq = s_rseq + 32'(e.length);
            emit_own(F_ACK, 0, 0); return;
         end
         retransmit_check(); return;
      end
      if (s_mode == M_LAST) begin
         if (s_flags & A_ACKED) begin
            s_mode = M_DISC; s_flags = A_CLOSE; return;
         end
         retransmit_check(); return;
      end
      emit_own(F_ACK, 0, 0);
   endfunction

   function automatic rsp_type predict_event(req_type e);
      logic nd;
      logic [17:0] sum;
      nd = 1'b0;
      out_hdr = '0;
      case (cmd_type'(e.cmd))
         CMD_CONNECT: begin
            s_lseq = e.init_seq; s_rseq = 0; s_lport = s_lport + 1; s_unack = 1;
            s_timer = 8'(c_rto); s_tout = 8'(c_rto); s_sa = 0; s_sv = 16; s_rcnt = 0;
            s_mode = M_WAIT; s_idle = 0;
            emit_own(F_SYN, 1, 0);
         end
         CMD_SEND: begin
            if (s_mode == M_CONN) begin
               emit_own(F_ACK, 1, e.length);
               if (!(s_flags & A_REXMIT)) begin
                  sum = 18'(s_unack) + 18'(e.length);
                  s_unack = sum > 18'(UNACK_MAX) ? UNACK_MAX : sum[16:0];
                  s_timer = s_tout; s_rcnt = 0;
               end
            end
         end
         default: begin
            if (s_flags != 0) s_idle = 0;
            s_flags = 0;
            if (e.cmd == CMD_TICK && s_idle != 16'hFFFF) s_idle = s_idle + 1;
            if (s_idle >= c_inact) s_flags |= A_INACTIVE;
            if (s_mode == M_TOUT) s_mode = M_DISC;
            else if (s_mode != M_DISC) begin
               if (e.cmd == CMD_TICK) begin
                  if (s_unack > 0) s_timer = s_timer - 1;
                  retransmit_check();
               end else segment_event(e);
            end
            nd = (s_flags & A_NEWDATA) != 0;
         end
      endcase
      out_hdr.app_flags = s_flags;
      out_hdr.conn_state = s_mode;
      out_hdr.new_data = nd;
      return out_hdr;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Driver: feeds pending events, with random gaps.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (req.valid && !req.ready) begin
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req.valid <= 1'b0;
      end else if (pending_events.size() > 0) begin
         req.data <= pending_events[0];
         expected_beats.push_back(predict_event(pending_events.pop_front()));
         req.valid <= 1'b1;
         send_gap <= gap_len();
      end else begin
         req.valid <= 1'b0;
      end
   end

   // Monitor: receiver stalls at random and checks every response beat.
   int recv_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_beats.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response beat %p", rsp.data);
            end else begin
               if (rsp.data !== expected_beats[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch on beat %0d\n  expected %p\n  actual   %p",
                              beats_checked, expected_beats[0], rsp.data);
               end
               if (expected_beats[0].tx_valid) sent_segments++;
               void'(expected_beats.pop_front());
               beats_checked++;
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            recv_gap <= gap_len();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_watch <= 0;
      else idle_watch <= idle_watch + 1;
      if (idle_watch >= 2000) begin
         $display("watchdog expired, %0d beats outstanding", expected_beats.size());
         $display("** tcp_client_connection_engine_unit: FAILED **");
         $finish;
      end
   end

   task automatic csr_write(reg_type idx, logic [15:0] v);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00}); csr_pwdata <= {16'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      model_config(idx, v);
   endtask

   task automatic wait_drained();
      while (pending_events.size() > 0 || expected_beats.size() > 0 || req.valid)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic req_type noise_event();
      req_type e;
      e.cmd = 2'($urandom); e.ip_match = 1'($urandom); e.seg_src_port = 16'($urandom);
      e.seg_dst_port = 16'($urandom); e.seg_seq = $urandom; e.seg_ack = $urandom;
      e.seg_flags = 6'($urandom); e.length = 16'($urandom_range(0, 65515));
      e.init_seq = $urandom;
      return e;
   endfunction

   function automatic req_type make_event(cmd_type c, logic [5:0] fl, logic [31:0] sq,
                                          logic [31:0] ak, logic [15:0] len);
      req_type e;
      e = noise_event();
      e.cmd = c; e.ip_match = 1'b1; e.seg_src_port = c_rport; e.seg_dst_port = s_lport;
      e.seg_flags = fl; e.seg_seq = sq; e.seg_ack = ak; e.length = len;
      return e;
   endfunction

   // Shadow state of the remote side, tracked as events are queued.
   logic [31:0] peer_seq, my_next;
   logic [15:0] plan_port;

   function automatic logic [15:0] rand_len();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return 16'($urandom_range(1, 1500));
      if (r < 8) return 16'd0;
      if (r < 9) return 16'd65515;
      return 16'($urandom_range(0, 65515));
   endfunction

   // One well-formed session with random content and occasional corruption.
   task automatic queue_session();
      req_type e;
      logic [31:0] isn;
      logic [15:0] l;
      int n;
      isn = $urandom;
      e = noise_event(); e.cmd = CMD_CONNECT; e.init_seq = isn;
      pending_events.push_back(e);
      plan_port = plan_port + 1;
      my_next = isn + 1;
      peer_seq = $urandom;
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 30)) begin
            e = noise_event(); e.cmd = CMD_TICK; pending_events.push_back(e);
         end
      e = noise_event(); e.cmd = CMD_SEGMENT; e.ip_match = 1; e.seg_src_port = c_rport;
      e.seg_dst_port = plan_port; e.seg_flags = F_SYN | F_ACK; e.seg_seq = peer_seq;
      e.seg_ack = ($urandom_range(0, 9) == 0) ? $urandom : my_next; e.length = 0;
      pending_events.push_back(e);
      peer_seq = peer_seq + 1;
      n = $urandom_range(3, 20);
      repeat (n) begin
         e = noise_event();
         e.ip_match = ($urandom_range(0, 15) != 0); e.seg_src_port = c_rport;
         e.seg_dst_port = ($urandom_range(0, 15) == 0) ? 16'($urandom) : plan_port;
         case ($urandom_range(0, 5))
            0: begin
               e.cmd = CMD_SEND; l = rand_len(); e.length = l; my_next = my_next + l;
            end
            1: begin
               e.cmd = CMD_SEGMENT; e.seg_flags = F_ACK | 6'($urandom_range(0, 1) << 3);
               e.seg_seq = peer_seq; e.seg_ack = my_next; e.length = 0;
            end
            2: begin
               e.cmd = CMD_SEGMENT; e.seg_flags = F_ACK; l = rand_len();
               e.seg_seq = ($urandom_range(0, 7) == 0) ? $urandom : peer_seq;
               e.seg_ack = my_next; e.length = l;
               if (e.seg_seq == peer_seq) peer_seq = peer_seq + l;
            end
            3: begin
               e.cmd = CMD_TICK;
            end
            4: begin
               e.cmd = CMD_SEGMENT;
               e.seg_seq = peer_seq; e.seg_ack = my_next;
            end
            default: begin
               repeat ($urandom_range(1, 40)) begin
                  e = noise_event(); e.cmd = CMD_TICK; pending_events.push_back(e);
               end
               e = noise_event(); e.cmd = CMD_TICK;
            end
         endcase
         pending_events.push_back(e);
      end
      if ($urandom_range(0, 2) != 0) begin
         e = noise_event(); e.cmd = CMD_SEGMENT; e.ip_match = 1; e.seg_src_port = c_rport;
         e.seg_dst_port = plan_port; e.seg_flags = F_FIN | F_ACK; e.seg_seq = peer_seq;
         e.seg_ack = my_next; e.length = $urandom_range(0, 3) == 0 ? 16'd20 : 16'd0;
         pending_events.push_back(e);
         e.cmd = CMD_SEGMENT; e.seg_flags = F_ACK; e.length = 0;
         e.seg_seq = peer_seq + e.length + 1; e.seg_ack = my_next + 1;
         pending_events.push_back(e);
      end
   endtask

   task automatic random_phase(int count);
      int start;
      plan_port = s_lport;
      start = pending_events.size();
      while (pending_events.size() - start < count) begin
         if ($urandom_range(0, 9) < 8) queue_session();
         else pending_events.push_back(noise_event());
      end
      wait_drained();
   endtask

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
      model_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      csr_write(R_REMOTE_PORT, 16'd80);
      csr_write(R_FIRST_LOCAL, 16'hFFFF);
      csr_write(R_RTO_INIT, 16'd1);
      csr_write(R_MAX_RETX, 16'd1);
      csr_write(R_MAX_SYN, 16'd1);
      csr_write(R_INACT, 16'd1);

      // Directed: port wrap, SYN timeout, send when idle, reset replies.
      pending_events.push_back(make_event(CMD_SEND, 0, 0, 0, 100));
      pending_events.push_back(make_event(CMD_TICK, 0, 0, 0, 0));
      pending_events.push_back(make_event(CMD_CONNECT, 0, 0, 0, 0));
      pending_events[2].init_seq = 32'hFFFF_FFFF;
      repeat (4) pending_events.push_back(make_event(CMD_TICK, 0, 0, 0, 0));
      pending_events.push_back(make_event(CMD_CONNECT, 0, 0, 0, 0));
      pending_events[$].init_seq = 32'hFFFF_FFFE;
      begin
         req_type e;
         e = make_event(CMD_SEGMENT, F_SYN | F_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
         e.seg_dst_port = 16'd1;
         pending_events.push_back(e);
         e.seg_flags = F_ACK; e.seg_dst_port = 16'd7; pending_events.push_back(e);
         e.seg_flags = F_RST; pending_events.push_back(e);
         e.seg_dst_port = 16'd1; e.seg_flags = F_ACK | F_FIN; e.length = 65515;
         pending_events.push_back(e);
         e.cmd = CMD_SEND; e.length = 65515; pending_events.push_back(e);
         pending_events.push_back(e);
         e.cmd = CMD_TICK; pending_events.push_back(e);
         e.cmd = CMD_SEGMENT; e.seg_flags = F_RST; pending_events.push_back(e);
         e.ip_match = 0; e.cmd = CMD_SEGMENT; pending_events.push_back(e);
      end
      wait_drained();

      csr_write(R_RTO_INIT, 16'd15);
      csr_write(R_MAX_RETX, 16'd15);
      csr_write(R_MAX_SYN, 16'd15);
      csr_write(R_INACT, 16'hFFFF);
      csr_write(R_REMOTE_PORT, 16'hFFFF);
      random_phase(350);

      // Long receiver stall while the sender keeps offering beats.
      hold_off = 300;
      random_phase(100);

      csr_write(R_REMOTE_PORT, 16'd0);
      csr_write(R_FIRST_LOCAL, 16'd0);
      csr_write(R_RTO_INIT, 16'd3);
      csr_write(R_MAX_RETX, 16'd4);
      csr_write(R_MAX_SYN, 16'd2);
      csr_write(R_INACT, 16'd25);
      random_phase(400);

      csr_write(R_REMOTE_PORT, 16'($urandom));
      csr_write(R_RTO_INIT, 16'd8);
      csr_write(R_MAX_RETX, 16'd8);
      csr_write(R_MAX_SYN, 16'd5);
      csr_write(R_INACT, 16'd300);
      random_phase(450);

      repeat (20) @(posedge clock);
      $display("Checked %0d response beats, %0d carried a segment header.",
               beats_checked, sent_segments);
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("** tcp_client_connection_engine_unit: PASSED **");
      end else begin
         $display("%0d mismatches, %0d beats missing", mismatches, expected_beats.size());
         $display("** tcp_client_connection_engine_unit: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire

### files.f
+incdir+sv
sv/tce_pkg.sv
sv/tce_if.sv
sv/tce_step.sv
sv/tcp_client_connection_engine_unit.sv
verif/testbench.sv
